@@ src/xmbrt_pkg.sv @@
`timescale 1ns / 1ps

package xmbrt_pkg;

	// Table geometry.
	localparam int BUCKET_COUNT = 256;
	localparam int ID_BITS      = 256;
	localparam int BUCKET_SLOTS = 8;
	localparam int MAX_WANT     = 64;

	// Fixed field widths.
	localparam int WORD_BITS = 64;
	localparam int ID_W      = 256;
	localparam int WANT_W    = 7;
	localparam int CFG_IDX_W = 2;

	// Derived widths and depths.
	localparam int ID_WORDS    = (ID_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int WORD_IDX_W  = (ID_WORDS > 1) ? $clog2(ID_WORDS) : 1;
	localparam int POS_W       = 6;
	localparam int RAW_W       = WORD_IDX_W + POS_W;
	localparam int BUCKET_W    = $clog2(BUCKET_COUNT);
	localparam int SLOT_W      = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
	localparam int FILL_W      = $clog2(BUCKET_SLOTS + 1);
	localparam int ENTRY_DEPTH = BUCKET_COUNT << SLOT_W;
	localparam int ENTRY_AW    = BUCKET_W + SLOT_W;

	// Bits of an identifier that take part in the metric.
	localparam logic [ID_W-1:0] ID_MASK = {ID_W{1'b1}} >> (ID_W - ID_BITS);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_W3 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_W2 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_W1 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_W0 = 2'd3;

	// Input item kinds.
	localparam logic KIND_ADD  = 1'b0;
	localparam logic KIND_FIND = 1'b1;

	// Result status codes.
	typedef enum logic [2:0] {
		STS_ADDED = 3'd0,
		STS_FULL  = 3'd1,
		STS_OWN   = 3'd2,
		STS_FOUND = 3'd3,
		STS_NONE  = 3'd4
	} status_t;

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_BKT,
		S_FILL_RD,
		S_FILL_CHK,
		S_ENT_RD,
		S_ENT_USE,
		S_FLUSH,
		S_REPLY
	} state_t;

	// Result of the leading-bit search.
	typedef struct packed {
		logic                done;
		logic                zero;
		logic [BUCKET_W-1:0] bucket;
	} msb_res_t;

endpackage

@@ src/xmbrt_ram.sv @@
`timescale 1ns / 1ps

module xmbrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ src/xmbrt_msb.sv @@
`timescale 1ns / 1ps

module xmbrt_msb (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [xmbrt_pkg::ID_W-1:0] diff,
	output xmbrt_pkg::msb_res_t       res
);

	logic                              busy_q;
	logic [xmbrt_pkg::WORD_IDX_W-1:0]  k_q;
	logic [xmbrt_pkg::WORD_BITS-1:0]   word;
	logic [xmbrt_pkg::POS_W-1:0]       pos;
	logic [xmbrt_pkg::RAW_W-1:0]       raw;
	logic                              hit;

	// Scan the distance one word a cycle, from the top word down.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			k_q    <= xmbrt_pkg::WORD_IDX_W'(xmbrt_pkg::ID_WORDS - 1);
		end else if (busy_q) begin
			if (hit || k_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				k_q <= k_q - 1'b1;
			end
		end
	end

	// Priority encoder on the current word.
	always_comb begin
		word = diff[k_q * xmbrt_pkg::WORD_BITS +: xmbrt_pkg::WORD_BITS];
		pos  = '0;
		for (int i = 0; i < xmbrt_pkg::WORD_BITS; i++) begin
			if (word[i]) begin
				pos = xmbrt_pkg::POS_W'(i);
			end
		end
		hit = |word;
		raw = {k_q, pos};
	end

	// A leading bit beyond the table lands in the top bucket.
	always_comb begin
		res.done = busy_q && (hit || k_q == '0);
		res.zero = !hit;
		if (int'(raw) >= xmbrt_pkg::BUCKET_COUNT) begin
			res.bucket = xmbrt_pkg::BUCKET_W'(xmbrt_pkg::BUCKET_COUNT - 1);
		end else begin
			res.bucket = xmbrt_pkg::BUCKET_W'(raw);
		end
	end

endmodule

@@ src/xor_metric_bucket_routing_table.sv @@
`timescale 1ns / 1ps

// XOR-metric routing table: 256-bit node IDs kept in 256 buckets of 8 slots,
// the bucket being the highest differing bit against the own ID. One item is
// worked at a time; in_stall is high from acceptance until its last result
// is loaded into the output register. An add runs the leading-bit search
// (one 64-bit word a cycle), a read and check of the bucket fill count, and
// the reply; an add of the own ID skips the fill check. A find takes the
// same search, then a fill memory read and check for each bucket visited
// and an entry memory read and use for each ID returned; the single read
// port of each memory sets the pace of the walk, and a stalled output holds
// it. A find that wants no IDs goes straight to the reply. Stored IDs are
// emitted in insertion order within a bucket, from the target's bucket
// upward, then downward below it. No clearing pass is needed after reset:
// fill counts read as zero until their bucket is first written.
module xor_metric_bucket_routing_table (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [xmbrt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [xmbrt_pkg::WORD_BITS-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                kind,
	input  logic [xmbrt_pkg::WORD_BITS-1:0]     id_w3,
	input  logic [xmbrt_pkg::WORD_BITS-1:0]     id_w2,
	input  logic [xmbrt_pkg::WORD_BITS-1:0]     id_w1,
	input  logic [xmbrt_pkg::WORD_BITS-1:0]     id_w0,
	input  logic [xmbrt_pkg::WANT_W-1:0]        want_count,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [xmbrt_pkg::WORD_BITS-1:0]     node_w3,
	output logic [xmbrt_pkg::WORD_BITS-1:0]     node_w2,
	output logic [xmbrt_pkg::WORD_BITS-1:0]     node_w1,
	output logic [xmbrt_pkg::WORD_BITS-1:0]     node_w0,
	output logic [2:0]                          status,
	output logic                                last
);

	xmbrt_pkg::state_t                 state_q, state_d;
	logic [xmbrt_pkg::ID_W-1:0]        own_q;
	logic [xmbrt_pkg::ID_W-1:0]        id_q;
	logic                              kind_q;
	logic [xmbrt_pkg::WANT_W-1:0]      want_q;
	logic [xmbrt_pkg::WANT_W-1:0]      n_q;
	logic [xmbrt_pkg::BUCKET_W-1:0]    cur_q;
	logic [xmbrt_pkg::BUCKET_W-1:0]    start_q;
	logic                              down_q;
	logic [xmbrt_pkg::FILL_W-1:0]      fill_q;
	logic [xmbrt_pkg::FILL_W-1:0]      slot_q;
	logic [xmbrt_pkg::ID_W-1:0]        pend_q;
	logic                              pend_vld_q;
	xmbrt_pkg::status_t                reply_q;
	logic [xmbrt_pkg::BUCKET_COUNT-1:0] fill_vld_q;

	logic                              out_valid_q;
	logic [xmbrt_pkg::ID_W-1:0]        out_node_q;
	xmbrt_pkg::status_t                out_status_q;
	logic                              out_last_q;

	logic                              in_acc;
	logic                              out_free;
	logic [xmbrt_pkg::ID_W-1:0]        id_in;
	logic [xmbrt_pkg::WANT_W-1:0]      want_in;
	xmbrt_pkg::msb_res_t               msb;

	logic                              fill_re;
	logic                              fill_we;
	logic [xmbrt_pkg::FILL_W-1:0]      fill_rdata;
	logic [xmbrt_pkg::FILL_W-1:0]      fill_cur;
	logic                              ent_re;
	logic                              ent_we;
	logic [xmbrt_pkg::ENTRY_AW-1:0]    ent_waddr;
	logic [xmbrt_pkg::ENTRY_AW-1:0]    ent_raddr;
	logic [xmbrt_pkg::ID_W-1:0]        ent_rdata;

	logic                              push;
	logic [xmbrt_pkg::ID_W-1:0]        push_node;
	xmbrt_pkg::status_t                push_status;
	logic                              push_last;

	logic [xmbrt_pkg::BUCKET_W-1:0]    nxt_cur;
	logic                              nxt_down;
	logic                              walk_end;
	logic [xmbrt_pkg::WANT_W-1:0]      n_inc;

	// Working-register load controls from the state machine.
	logic                              ld_bucket;
	logic                              ld_fill;
	logic                              ld_next;
	logic                              ld_slot;
	logic                              ld_pend;
	logic                              ld_reply;
	xmbrt_pkg::status_t                reply_d;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != xmbrt_pkg::S_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign id_in    = {id_w3, id_w2, id_w1, id_w0} & xmbrt_pkg::ID_MASK;
	assign want_in  = (int'(want_count) > xmbrt_pkg::MAX_WANT) ?
			xmbrt_pkg::WANT_W'(xmbrt_pkg::MAX_WANT) : want_count;
	assign n_inc    = n_q + 1'b1;

	// Own identifier registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				xmbrt_pkg::CFG_OWN_W3: own_q[255:192] <= cfg_data;
				xmbrt_pkg::CFG_OWN_W2: own_q[191:128] <= cfg_data;
				xmbrt_pkg::CFG_OWN_W1: own_q[127:64]  <= cfg_data;
				xmbrt_pkg::CFG_OWN_W0: own_q[63:0]    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Leading differing bit search.
	xmbrt_msb u_msb (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_acc),
		.diff   ((id_q ^ own_q) & xmbrt_pkg::ID_MASK),
		.res    (msb)
	);

	// Fill count per bucket; a bucket never written reads as empty.
	xmbrt_ram #(
		.WIDTH (xmbrt_pkg::FILL_W),
		.DEPTH (xmbrt_pkg::BUCKET_COUNT)
	) u_fill_ram (
		.clk   (clk),
		.we    (fill_we),
		.waddr (cur_q),
		.wdata (xmbrt_pkg::FILL_W'(fill_cur + 1'b1)),
		.re    (fill_re),
		.raddr (cur_q),
		.rdata (fill_rdata)
	);

	assign fill_cur = fill_vld_q[cur_q] ? fill_rdata : '0;

	// Stored identifiers, one row of slots per bucket.
	xmbrt_ram #(
		.WIDTH (xmbrt_pkg::ID_W),
		.DEPTH (xmbrt_pkg::ENTRY_DEPTH)
	) u_ent_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (id_q),
		.re    (ent_re),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	assign ent_waddr = {cur_q, fill_cur[xmbrt_pkg::SLOT_W-1:0]};
	assign ent_raddr = {cur_q, slot_q[xmbrt_pkg::SLOT_W-1:0]};

	// Next bucket of the walk: upward to the top, then downward from below the start.
	always_comb begin
		nxt_cur  = cur_q;
		nxt_down = down_q;
		walk_end = 1'b0;
		if (!down_q) begin
			if (cur_q == xmbrt_pkg::BUCKET_W'(xmbrt_pkg::BUCKET_COUNT - 1)) begin
				if (start_q == '0) begin
					walk_end = 1'b1;
				end else begin
					nxt_cur  = start_q - 1'b1;
					nxt_down = 1'b1;
				end
			end else begin
				nxt_cur = cur_q + 1'b1;
			end
		end else begin
			if (cur_q == '0) begin
				walk_end = 1'b1;
			end else begin
				nxt_cur = cur_q - 1'b1;
			end
		end
	end

	// Next state, memory controls and output loads.
	always_comb begin
		state_d     = state_q;
		fill_re     = 1'b0;
		fill_we     = 1'b0;
		ent_re      = 1'b0;
		ent_we      = 1'b0;
		push        = 1'b0;
		push_node   = '0;
		push_status = xmbrt_pkg::STS_NONE;
		push_last   = 1'b1;
		ld_bucket   = 1'b0;
		ld_fill     = 1'b0;
		ld_next     = 1'b0;
		ld_slot     = 1'b0;
		ld_pend     = 1'b0;
		ld_reply    = 1'b0;
		reply_d     = xmbrt_pkg::STS_NONE;
		unique case (state_q)
			xmbrt_pkg::S_IDLE: begin
				if (in_acc) begin
					state_d = xmbrt_pkg::S_BKT;
				end
			end
			xmbrt_pkg::S_BKT: begin
				if (msb.done) begin
					if (kind_q == xmbrt_pkg::KIND_ADD && msb.zero) begin
						ld_reply = 1'b1;
						reply_d  = xmbrt_pkg::STS_OWN;
						state_d  = xmbrt_pkg::S_REPLY;
					end else if (kind_q == xmbrt_pkg::KIND_FIND && want_q == '0) begin
						ld_reply = 1'b1;
						reply_d  = xmbrt_pkg::STS_NONE;
						state_d  = xmbrt_pkg::S_REPLY;
					end else begin
						ld_bucket = 1'b1;
						state_d   = xmbrt_pkg::S_FILL_RD;
					end
				end
			end
			xmbrt_pkg::S_FILL_RD: begin
				fill_re = 1'b1;
				state_d = xmbrt_pkg::S_FILL_CHK;
			end
			xmbrt_pkg::S_FILL_CHK: begin
				if (kind_q == xmbrt_pkg::KIND_ADD) begin
					ld_reply = 1'b1;
					state_d  = xmbrt_pkg::S_REPLY;
					if (int'(fill_cur) >= xmbrt_pkg::BUCKET_SLOTS) begin
						reply_d = xmbrt_pkg::STS_FULL;
					end else begin
						reply_d = xmbrt_pkg::STS_ADDED;
						fill_we = 1'b1;
						ent_we  = 1'b1;
					end
				end else if (fill_cur == '0) begin
					if (walk_end) begin
						state_d = xmbrt_pkg::S_FLUSH;
					end else begin
						ld_next = 1'b1;
						state_d = xmbrt_pkg::S_FILL_RD;
					end
				end else begin
					ld_fill = 1'b1;
					state_d = xmbrt_pkg::S_ENT_RD;
				end
			end
			xmbrt_pkg::S_ENT_RD: begin
				ent_re  = 1'b1;
				state_d = xmbrt_pkg::S_ENT_USE;
			end
			xmbrt_pkg::S_ENT_USE: begin
				// The held entry goes out once a newer one proves it is not the last.
				if (!pend_vld_q || out_free) begin
					push        = pend_vld_q;
					push_node   = pend_q;
					push_status = xmbrt_pkg::STS_FOUND;
					push_last   = 1'b0;
					ld_pend     = 1'b1;
					if (n_inc == want_q) begin
						state_d = xmbrt_pkg::S_FLUSH;
					end else if (xmbrt_pkg::FILL_W'(slot_q + 1'b1) == fill_q) begin
						if (walk_end) begin
							state_d = xmbrt_pkg::S_FLUSH;
						end else begin
							ld_next = 1'b1;
							state_d = xmbrt_pkg::S_FILL_RD;
						end
					end else begin
						ld_slot = 1'b1;
						state_d = xmbrt_pkg::S_ENT_RD;
					end
				end
			end
			xmbrt_pkg::S_FLUSH: begin
				if (out_free) begin
					push        = 1'b1;
					push_node   = pend_vld_q ? pend_q : '0;
					push_status = pend_vld_q ? xmbrt_pkg::STS_FOUND : xmbrt_pkg::STS_NONE;
					state_d     = xmbrt_pkg::S_IDLE;
				end
			end
			xmbrt_pkg::S_REPLY: begin
				if (out_free) begin
					push        = 1'b1;
					push_status = reply_q;
					state_d     = xmbrt_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = xmbrt_pkg::S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= xmbrt_pkg::S_IDLE;
			fill_vld_q <= '0;
			pend_vld_q <= 1'b0;
			n_q        <= '0;
			down_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fill_we) begin
				fill_vld_q[cur_q] <= 1'b1;
			end
			if (ld_bucket) begin
				pend_vld_q <= 1'b0;
				n_q        <= '0;
				down_q     <= 1'b0;
			end else begin
				if (ld_pend) begin
					pend_vld_q <= 1'b1;
					n_q        <= n_inc;
				end
				if (ld_next) begin
					down_q <= nxt_down;
				end
			end
		end
	end

	// Item and walk payload registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			id_q   <= id_in;
			kind_q <= kind;
			want_q <= want_in;
		end
		if (ld_bucket) begin
			cur_q   <= msb.zero ? '0 : msb.bucket;
			start_q <= msb.zero ? '0 : msb.bucket;
		end else if (ld_next) begin
			cur_q <= nxt_cur;
		end
		if (ld_fill) begin
			fill_q <= fill_cur;
			slot_q <= '0;
		end else if (ld_slot) begin
			slot_q <= slot_q + 1'b1;
		end
		if (ld_pend) begin
			pend_q <= ent_rdata;
		end
		if (ld_reply) begin
			reply_q <= reply_d;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_node_q   <= push_node;
			out_status_q <= push_status;
			out_last_q   <= push_last;
		end
	end

	assign out_valid = out_valid_q;
	assign node_w3   = out_node_q[255:192];
	assign node_w2   = out_node_q[191:128];
	assign node_w1   = out_node_q[127:64];
	assign node_w0   = out_node_q[63:0];
	assign status    = out_status_q;
	assign last      = out_last_q;

endmodule

@@ src/xmbrt_checker.sv @@
`timescale 1ns / 1ps

module xmbrt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] node_w3,
	input logic [63:0] node_w2,
	input logic [63:0] node_w1,
	input logic [63:0] node_w0,
	input logic [2:0]  status,
	input logic        last
);

	// A held result beat keeps its status, its last flag and its lowest node word.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(last)
			&& $stable(node_w0))
		else $error("stalled result beat changed");

	// An accepted item keeps the input side closed in the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted while busy");

	// Every status other than a found entry ends its item.
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != xmbrt_pkg::STS_FOUND |-> last)
		else $error("non-find result without last");

	// Only a found entry carries an identifier.
	a_zero_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != xmbrt_pkg::STS_FOUND |->
			node_w3 == '0 && node_w2 == '0 && node_w1 == '0 && node_w0 == '0)
		else $error("identifier on a non-find result");

	// Status codes stay within the defined set.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= xmbrt_pkg::STS_NONE)
		else $error("undefined status code");

endmodule

bind xor_metric_bucket_routing_table xmbrt_checker u_xmbrt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.node_w3   (node_w3),
	.node_w2   (node_w2),
	.node_w1   (node_w1),
	.node_w0   (node_w0),
	.status    (status),
	.last      (last)
);
